// ===== hw/rtl/lfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfd_pkg
// shared constants and types of the rangefinder frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package lfd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned POS_W      = 4;

  localparam logic [BYTE_W-1:0] FRAME_HEAD = 8'h59;
  localparam logic [BYTE_W-1:0] FRAME_TAIL = 8'h0A;

  // byte positions inside a frame
  localparam logic [POS_W-1:0] POS_HEAD0 = 4'd0;
  localparam logic [POS_W-1:0] POS_HEAD1 = 4'd1;
  localparam logic [POS_W-1:0] POS_DIST_LO = 4'd2;
  localparam logic [POS_W-1:0] POS_DIST_HI = 4'd3;
  localparam logic [POS_W-1:0] POS_STR_LO  = 4'd4;
  localparam logic [POS_W-1:0] POS_STR_HI  = 4'd5;
  localparam logic [POS_W-1:0] POS_CHECK   = 4'd8;
  localparam logic [POS_W-1:0] POS_LAST    = 4'd9;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_FRAMING  = 2'd2
  } frame_status_t;

  // one finished frame, handed from the parser to the output register
  typedef struct packed {
    logic              last;
    logic [VALUE_W-1:0] distance;
    logic [VALUE_W-1:0] strength;
    frame_status_t     frame_status;
  } frame_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lfd_parse.sv =====
// ----------------------------------------------------------------------------
// lfd_parse
// frame position, checksum and field capture for one byte per cycle while byte_en is high
// ----------------------------------------------------------------------------
`default_nettype none

module lfd_parse
  import lfd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                byte_en,
  input  wire logic [BYTE_W-1:0]   data_byte,
  output frame_result_t            result
);

  logic [POS_W-1:0]   byte_position;
  logic [BYTE_W-1:0]  running_sum;
  logic               header_good;
  logic [VALUE_W-1:0] distance_hold;
  logic [VALUE_W-1:0] strength_hold;
  logic [BYTE_W-1:0]  received_check;

  logic               is_last;
  frame_status_t      status;

  // any position past the end counts as the last byte
  assign is_last = (byte_position >= POS_LAST);

  always_comb begin
    if (!header_good || (data_byte != FRAME_TAIL)) begin
      status = ST_FRAMING;
    end else if (running_sum != received_check) begin
      status = ST_CHECKSUM;
    end else begin
      status = ST_OK;
    end
    result.last         = is_last;
    result.frame_status = status;
    result.distance     = (status == ST_OK) ? distance_hold : '0;
    result.strength     = (status == ST_OK) ? strength_hold : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      running_sum    <= '0;
      header_good    <= 1'b0;
      distance_hold  <= '0;
      strength_hold  <= '0;
      received_check <= '0;
    end else if (byte_en) begin
      if (byte_position < POS_LAST - POS_W'(1)) begin
        running_sum <= ((byte_position == POS_HEAD0) ? '0 : running_sum) + data_byte;
      end
      unique case (byte_position)
        POS_HEAD0:   header_good <= (data_byte == FRAME_HEAD);
        POS_HEAD1:   header_good <= header_good && (data_byte == FRAME_HEAD);
        POS_DIST_LO: distance_hold[BYTE_W-1:0]       <= data_byte;
        POS_DIST_HI: distance_hold[VALUE_W-1:BYTE_W] <= data_byte;
        POS_STR_LO:  strength_hold[BYTE_W-1:0]       <= data_byte;
        POS_STR_HI:  strength_hold[VALUE_W-1:BYTE_W] <= data_byte;
        POS_CHECK:   received_check <= data_byte;
        default: ;
      endcase
      byte_position <= is_last ? '0 : byte_position + POS_W'(1);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lidar_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// lidar_frame_deframer_top
// cuts a rangefinder byte stream into 10-byte frames and reports each frame
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one raw sensor byte per word in s_tdata[7:0]
//   m_* channel: one word per frame, on the tenth byte of each frame
//     m_tdata  = {strength, distance}, m_tuser = frame status
//     status 0 ok, 1 checksum mismatch, 2 header or trailer wrong;
//     distance and strength read zero unless the status is ok
//   frames are aligned to the first byte after reset, no resync
// timing
//   one byte accepted per cycle, except while a last byte waits for the
//   result slot; bytes go through an input register, then the parser
//   updates its state and fills the result register that drives m_*
// reset
//   rst (synchronous, high) empties both registers and restarts at byte 0
// stalls
//   while a result waits on m_tready, bytes that produce no result keep
//   flowing; only the last byte of the next frame waits for the slot
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_frame_deframer_top
  import lfd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // slave side: sensor bytes
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [BYTE_W-1:0]    s_tdata,   // [7:0] data_byte
  // master side: frame results
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [2*VALUE_W-1:0]      m_tdata,   // [15:0] distance, [31:16] strength
  output logic [1:0]                m_tuser    // [1:0] frame_status
);

  // input register
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;

  // result register
  logic              out_valid;
  logic [VALUE_W-1:0] out_distance;
  logic [VALUE_W-1:0] out_strength;
  frame_status_t     out_status;

  frame_result_t     result;
  logic              slot_free;
  logic              advance;

  lfd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .byte_en   (advance),
    .data_byte (in_byte),
    .result    (result)
  );

  // result slot is free if empty or being drained this cycle
  assign slot_free = !out_valid || m_tready;
  // a non-final byte never needs the slot
  assign advance   = in_valid && (!result.last || slot_free);
  assign s_tready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.last) begin
      out_distance <= result.distance;
      out_strength <= result.strength;
      out_status   <= result.frame_status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_strength, out_distance};
  assign m_tuser  = out_status;

endmodule

`default_nettype wire
